FILE: sv/xnpr_pkg.sv
// xnpr_pkg: shared types and constants for the x86 next-pc resolver
// request and response payload structs, decode codes, architectural state bundle
// no dependencies
`default_nettype none

package xnpr_pkg;

    localparam int NUM_GPR = 16;
    localparam int GPR_AW  = 4;

    // request types
    localparam logic REQ_WRITE   = 1'b0;
    localparam logic REQ_RESOLVE = 1'b1;

    // register file entries outside the general registers
    localparam logic [4:0] ENT_IP    = 5'd16;
    localparam logic [4:0] ENT_FLAGS = 5'd17;

    // operand register codes
    localparam logic [4:0] REG_RCX     = 5'd1;
    localparam logic [4:0] REG_RSP     = 5'd4;
    localparam logic [4:0] REG_RIP     = 5'd16;
    localparam logic [4:0] REG_FIRST32 = 5'd17;
    localparam logic [4:0] REG_LAST32  = 5'd24;
    localparam logic [4:0] REG_EIP     = 5'd25;

    // instruction classes
    localparam logic [4:0] CLS_NEAR_RET  = 5'd1;
    localparam logic [4:0] CLS_FAR_RET   = 5'd2;
    localparam logic [4:0] CLS_CALL_JMP  = 5'd3;
    localparam logic [4:0] CLS_JCC_FIRST = 5'd4;
    localparam logic [4:0] CLS_JCC_LAST  = 5'd19;
    localparam logic [4:0] CLS_JCXZ      = 5'd20;
    localparam logic [4:0] CLS_JECXZ     = 5'd21;
    localparam logic [4:0] CLS_JRCXZ     = 5'd22;
    localparam logic [4:0] CLS_LOOP      = 5'd23;
    localparam logic [4:0] CLS_LOOPE     = 5'd24;
    localparam logic [4:0] CLS_LOOPNE    = 5'd25;

    // operand kinds
    localparam logic [1:0] KIND_IMM = 2'd0;
    localparam logic [1:0] KIND_REG = 2'd1;
    localparam logic [1:0] KIND_MEM = 2'd2;

    // loop count widths
    localparam logic [1:0] AW_16 = 2'd0;
    localparam logic [1:0] AW_32 = 2'd1;
    localparam logic [1:0] AW_64 = 2'd2;

    // condition pairs (bit 0 of the code inverts)
    localparam logic [2:0] CC_O  = 3'd0;
    localparam logic [2:0] CC_B  = 3'd1;
    localparam logic [2:0] CC_Z  = 3'd2;
    localparam logic [2:0] CC_BE = 3'd3;
    localparam logic [2:0] CC_S  = 3'd4;
    localparam logic [2:0] CC_P  = 3'd5;
    localparam logic [2:0] CC_L  = 3'd6;
    localparam logic [2:0] CC_LE = 3'd7;

    // flag bit positions
    localparam int FLAG_CF = 0;
    localparam int FLAG_PF = 2;
    localparam int FLAG_ZF = 6;
    localparam int FLAG_SF = 7;
    localparam int FLAG_OF = 11;

    // branch status
    localparam logic [1:0] ST_NONE      = 2'd0;
    localparam logic [1:0] ST_NOT_TAKEN = 2'd1;
    localparam logic [1:0] ST_TAKEN     = 2'd2;

    // pointer sizes
    localparam logic [3:0] PSZ_4 = 4'd4;
    localparam logic [3:0] PSZ_8 = 4'd8;

    typedef struct packed {
        logic               req_type;
        logic [4:0]         write_reg;
        logic [63:0]        write_value;
        logic [4:0]         instr_class;
        logic [3:0]         instr_length;
        logic [1:0]         operand_kind;
        logic [4:0]         base_reg;
        logic [4:0]         index_reg;
        logic [3:0]         scale;
        logic signed [31:0] signed_offset;
        logic [1:0]         count_width;
        logic               compat32;
    } req_item_t;

    typedef struct packed {
        logic [1:0]  branch_status;
        logic [63:0] target_address;
        logic [63:0] pointer_address;
        logic [3:0]  pointer_size;
    } rsp_item_t;

    typedef struct packed {
        logic [63:0] ip;
        logic [63:0] flags;
        logic [63:0] rcx;
        logic [63:0] rsp;
    } arch_state_t;

endpackage

`default_nettype wire

FILE: sv/xnpr_ram.sv
// xnpr_ram: generic single-write, single-read synchronous ram with registered read
// width and depth set by parameters; no package dependency
`default_nettype none

module xnpr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: sv/xnpr_eval.sv
// xnpr_eval: next-pc evaluation for one decoded instruction
// uses xnpr_pkg types and codes; operand data comes from the register file rams
`default_nettype none

module xnpr_eval (
    input  xnpr_pkg::req_item_t   item,
    input  logic [63:0]           base_data,
    input  logic [63:0]           index_data,
    input  xnpr_pkg::arch_state_t arch,
    input  logic                  host64,
    output xnpr_pkg::rsp_item_t   result
);
    import xnpr_pkg::*;

    typedef struct packed {
        logic        ok;
        logic [63:0] value;
    } operand_t;

    function automatic operand_t read_operand(
        input logic [4:0]  code,
        input logic [63:0] gpr,
        input logic [63:0] ip,
        input logic        h64
    );
        operand_t op;
        op.ok    = 1'b0;
        op.value = '0;
        if (code < REG_RIP)
        begin
            op.ok    = h64;
            op.value = gpr;
        end
        else if (code == REG_RIP)
        begin
            op.ok    = h64;
            op.value = ip;
        end
        else if (code <= REG_LAST32)
        begin
            op.ok    = 1'b1;
            op.value = {32'd0, gpr[31:0]};
        end
        else if (code == REG_EIP)
        begin
            op.ok    = 1'b1;
            op.value = {32'd0, ip[31:0]};
        end
        return op;
    endfunction

    function automatic logic cond_true(input logic [3:0] cc, input logic [63:0] fl);
        logic r;
        r = 1'b0;
        unique case (cc[3:1])
            CC_O:    r = fl[FLAG_OF];
            CC_B:    r = fl[FLAG_CF];
            CC_Z:    r = fl[FLAG_ZF];
            CC_BE:   r = fl[FLAG_CF] | fl[FLAG_ZF];
            CC_S:    r = fl[FLAG_SF];
            CC_P:    r = fl[FLAG_PF];
            CC_L:    r = fl[FLAG_SF] ^ fl[FLAG_OF];
            CC_LE:   r = fl[FLAG_ZF] | (fl[FLAG_SF] ^ fl[FLAG_OF]);
            default: r = 1'b0;
        endcase
        return cc[0] ? ~r : r;
    endfunction

    logic [63:0] off64;
    logic [63:0] len64;
    logic [63:0] ip_jump_full;
    logic [63:0] ip_fall_full;
    logic [63:0] ip_jump;
    logic [63:0] ip_fall;
    logic        wide_ptr;
    operand_t    base_op;
    operand_t    index_op;
    logic [63:0] base_term;
    logic [63:0] rel_term;
    logic [63:0] index_term;
    logic [63:0] mem_sum;
    logic [63:0] rcx16;
    logic [63:0] rcx32;
    logic [63:0] rcx64;
    logic [63:0] jcxz_count;
    logic [63:0] loop_count;
    logic [3:0]  cc;
    logic [63:0] imm;
    logic [63:0] ptr;
    logic [3:0]  psz;
    logic        is_branch;
    logic        taken;

    assign off64        = {{32{item.signed_offset[31]}}, item.signed_offset};
    assign len64        = {60'd0, item.instr_length};
    assign ip_jump_full = arch.ip + len64 + off64;
    assign ip_fall_full = arch.ip + len64;
    assign ip_jump      = host64 ? ip_jump_full : {32'd0, ip_jump_full[31:0]};
    assign ip_fall      = host64 ? ip_fall_full : {32'd0, ip_fall_full[31:0]};
    assign wide_ptr     = host64 & ~item.compat32;

    assign base_op    = read_operand(item.base_reg, base_data, arch.ip, host64);
    assign index_op   = read_operand(item.index_reg, index_data, arch.ip, host64);
    assign base_term  = base_op.ok ? base_op.value : '0;
    assign rel_term   = (base_op.ok && (item.base_reg == REG_RIP || item.base_reg == REG_EIP))
                        ? len64 : '0;
    assign index_term = index_op.ok ? index_op.value * {60'd0, item.scale} : '0;
    assign mem_sum    = base_term + rel_term + index_term + off64;

    assign rcx16 = {48'd0, arch.rcx[15:0]};
    assign rcx32 = {32'd0, arch.rcx[31:0]};
    assign rcx64 = host64 ? arch.rcx : rcx32;
    assign cc    = 4'(item.instr_class - CLS_JCC_FIRST);

    assign jcxz_count = (item.instr_class == CLS_JCXZ)  ? rcx16 :
                        (item.instr_class == CLS_JECXZ) ? rcx32 : rcx64;

    always_comb
    begin
        case (item.count_width)
            AW_16:   loop_count = rcx16;
            AW_32:   loop_count = rcx32;
            AW_64:   loop_count = rcx64;
            default: loop_count = 64'd1;
        endcase
    end

    always_comb
    begin
        imm       = '0;
        ptr       = '0;
        psz       = '0;
        is_branch = 1'b1;
        taken     = 1'b0;
        unique case (item.instr_class) inside
            CLS_NEAR_RET:
            begin
                ptr = wide_ptr ? arch.rsp : {32'd0, arch.rsp[31:0]};
                psz = wide_ptr ? PSZ_8 : PSZ_4;
            end
            CLS_FAR_RET:
            begin
                ptr = '0;
            end
            CLS_CALL_JMP:
            begin
                case (item.operand_kind)
                    KIND_IMM: imm = ip_jump;
                    KIND_REG: imm = base_term;
                    KIND_MEM:
                    begin
                        if (mem_sum != '0)
                        begin
                            ptr = wide_ptr ? mem_sum : {32'd0, mem_sum[31:0]};
                            psz = wide_ptr ? PSZ_8 : PSZ_4;
                        end
                    end
                    default: imm = '0;
                endcase
            end
            [CLS_JCC_FIRST:CLS_JCC_LAST]:
            begin
                taken = cond_true(cc, arch.flags);
            end
            [CLS_JCXZ:CLS_JRCXZ]:
            begin
                taken = (jcxz_count == '0);
            end
            [CLS_LOOP:CLS_LOOPNE]:
            begin
                taken = (loop_count != 64'd1);
                if (item.instr_class == CLS_LOOPE)
                begin
                    taken = taken & arch.flags[FLAG_ZF];
                end
                if (item.instr_class == CLS_LOOPNE)
                begin
                    taken = taken & ~arch.flags[FLAG_ZF];
                end
            end
            default:
            begin
                is_branch = 1'b0;
            end
        endcase

        if (taken && item.operand_kind == KIND_IMM)
        begin
            imm = ip_jump;
        end

        if (imm == '0 && ptr == '0 && psz == '0)
        begin
            result.branch_status  = is_branch ? ST_NOT_TAKEN : ST_NONE;
            result.target_address = ip_fall;
        end
        else
        begin
            result.branch_status  = is_branch ? ST_TAKEN : ST_NONE;
            result.target_address = imm;
        end
        result.pointer_address = ptr;
        result.pointer_size    = psz;
    end

endmodule

`default_nettype wire

FILE: sv/x86_next_pc_resolver.sv
// x86_next_pc_resolver: top level of the next-pc resolver
// uses xnpr_pkg, xnpr_ram (general register file copies) and xnpr_eval
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_item (xnpr_pkg::req_item_t)
//   rsp      out        rsp_valid/rsp_stall  rsp_item (xnpr_pkg::rsp_item_t)
//   cfg      in         cfg_valid/cfg_ready  cfg_data (host_is_64bit)
//
// one request transfer per cycle while req_stall is low
// a resolve passes the first stage, then the response register; write requests give no response
// the ram read for base and index sets the first stage, evaluation and the three-input add the second
// reset: register file reads as zero through per-entry valid bits, no clearing pass
// req_stall rises only while the evaluation stage is full and the response register is held
`default_nettype none

module x86_next_pc_resolver (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  xnpr_pkg::req_item_t req_item,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output xnpr_pkg::rsp_item_t rsp_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);
    import xnpr_pkg::*;

    function automatic logic [GPR_AW-1:0] gpr_addr(input logic [4:0] code);
        logic [4:0] rel;
        rel = code - REG_FIRST32;
        return (code >= REG_FIRST32) ? rel[GPR_AW-1:0] : code[GPR_AW-1:0];
    endfunction

    logic                req_accept;
    logic                rd_en;
    logic                wr_en;
    logic [GPR_AW-1:0]   base_addr;
    logic [GPR_AW-1:0]   index_addr;
    logic [63:0]         base_q;
    logic [63:0]         index_q;
    logic [63:0]         base_data;
    logic [63:0]         index_data;
    logic                s1_adv;
    rsp_item_t           eval_result;

    logic                host64_reg;
    logic                host64_next;
    arch_state_t         arch_reg;
    arch_state_t         arch_next;
    logic [NUM_GPR-1:0]  gpr_vld_reg;
    logic [NUM_GPR-1:0]  gpr_vld_next;
    logic                base_vld_reg;
    logic                base_vld_next;
    logic                index_vld_reg;
    logic                index_vld_next;
    logic                s1_valid_reg;
    logic                s1_valid_next;
    req_item_t           s1_item_reg;
    req_item_t           s1_item_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    rsp_item_t           rsp_item_reg;
    rsp_item_t           rsp_item_next;

    assign s1_adv     = ~rsp_valid_reg | ~rsp_stall;
    assign req_stall  = s1_valid_reg & ~s1_adv;
    assign req_accept = req_valid & ~req_stall;
    assign rd_en      = req_accept & (req_item.req_type == REQ_RESOLVE);
    assign wr_en      = req_accept & (req_item.req_type == REQ_WRITE)
                        & (req_item.write_reg < 5'(NUM_GPR));
    assign base_addr  = gpr_addr(req_item.base_reg);
    assign index_addr = gpr_addr(req_item.index_reg);
    assign cfg_ready  = 1'b1;

    xnpr_ram #(
        .WIDTH (64),
        .DEPTH (NUM_GPR)
    ) u_base_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (req_item.write_reg[GPR_AW-1:0]),
        .wr_data (req_item.write_value),
        .rd_en   (rd_en),
        .rd_addr (base_addr),
        .rd_data (base_q)
    );

    xnpr_ram #(
        .WIDTH (64),
        .DEPTH (NUM_GPR)
    ) u_index_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (req_item.write_reg[GPR_AW-1:0]),
        .wr_data (req_item.write_value),
        .rd_en   (rd_en),
        .rd_addr (index_addr),
        .rd_data (index_q)
    );

    assign base_data  = base_vld_reg ? base_q : '0;
    assign index_data = index_vld_reg ? index_q : '0;

    xnpr_eval u_eval (
        .item       (s1_item_reg),
        .base_data  (base_data),
        .index_data (index_data),
        .arch       (arch_reg),
        .host64     (host64_reg),
        .result     (eval_result)
    );

    always_comb
    begin
        host64_next    = host64_reg;
        arch_next      = arch_reg;
        gpr_vld_next   = gpr_vld_reg;
        base_vld_next  = base_vld_reg;
        index_vld_next = index_vld_reg;
        s1_valid_next  = s1_valid_reg;
        s1_item_next   = s1_item_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_item_next  = rsp_item_reg;

        if (cfg_valid && cfg_ready)
        begin
            host64_next = cfg_data;
        end

        // write transfer: general register copies and shadow state
        if (req_accept && req_item.req_type == REQ_WRITE)
        begin
            if (wr_en)
            begin
                gpr_vld_next[req_item.write_reg[GPR_AW-1:0]] = 1'b1;
            end
            if (req_item.write_reg == REG_RCX)
            begin
                arch_next.rcx = req_item.write_value;
            end
            if (req_item.write_reg == REG_RSP)
            begin
                arch_next.rsp = req_item.write_value;
            end
            if (req_item.write_reg == ENT_IP)
            begin
                arch_next.ip = req_item.write_value;
            end
            if (req_item.write_reg == ENT_FLAGS)
            begin
                arch_next.flags = req_item.write_value;
            end
        end

        // response register
        if (s1_adv)
        begin
            rsp_valid_next = s1_valid_reg;
            rsp_item_next  = eval_result;
            s1_valid_next  = 1'b0;
        end

        // resolve transfer into the evaluation stage
        if (rd_en)
        begin
            s1_valid_next  = 1'b1;
            s1_item_next   = req_item;
            base_vld_next  = gpr_vld_reg[base_addr];
            index_vld_next = gpr_vld_reg[index_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            host64_reg    <= 1'b1;
            arch_reg      <= '0;
            gpr_vld_reg   <= '0;
            base_vld_reg  <= 1'b0;
            index_vld_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            host64_reg    <= host64_next;
            arch_reg      <= arch_next;
            gpr_vld_reg   <= gpr_vld_next;
            base_vld_reg  <= base_vld_next;
            index_vld_reg <= index_vld_next;
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg  <= s1_item_next;
        rsp_item_reg <= rsp_item_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

`ifndef NO_ASSERTIONS
    a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && rsp_valid_reg && rsp_stall |-> req_stall)
        else $error("evaluation stage overwritten while response held");

    a_resolve_enters: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req_item.req_type == REQ_RESOLVE |=> s1_valid_reg)
        else $error("resolve transfer lost before evaluation");

    a_pointer_taken: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_item_reg.pointer_size != 4'd0
        |-> rsp_item_reg.branch_status == ST_TAKEN)
        else $error("pointer response without taken status");

    a_not_taken_no_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_item_reg.branch_status == ST_NOT_TAKEN
        |-> rsp_item_reg.pointer_address == 64'd0 && rsp_item_reg.pointer_size == 4'd0)
        else $error("not-taken response carries a pointer");
`endif

endmodule

`default_nettype wire

FILE: bench/x86_next_pc_resolver_checker.sv
// x86_next_pc_resolver_checker: watches the request, response and config channels,
// predicts each response of the next-pc resolver and compares it field by field
// depends on xnpr_pkg
`timescale 1ns / 100ps

module x86_next_pc_resolver_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_stall,
    input  xnpr_pkg::req_item_t req_item,
    input  logic                rsp_valid,
    input  logic                rsp_stall,
    input  xnpr_pkg::rsp_item_t rsp_item,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic                cfg_data,
    output int                  mismatch_count,
    output int                  pending_count
);
    import xnpr_pkg::*;

    logic [63:0] gpr_file [0:17];
    logic        host64;
    rsp_item_t   next_pc_expected [$];
    rsp_item_t   seen_rsp;
    rsp_item_t   want_rsp;

    initial mismatch_count = 0;

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] seen);
        $display("%0t mismatch %s: expected %h got %h", $time, what, want, seen);
        mismatch_count++;
    endtask

    function automatic logic [63:0] ip_advance(input logic [63:0] delta);
        logic [63:0] v;
        v = gpr_file[ENT_IP] + delta;
        return host64 ? v : {32'd0, v[31:0]};
    endfunction

    function automatic logic operand_value(input logic [4:0] code, output logic [63:0] val);
        val = '0;
        if (code <= REG_RIP)
        begin
            if (!host64)
                return 1'b0;
            val = gpr_file[code];
            return 1'b1;
        end
        if (code >= REG_FIRST32 && code <= REG_LAST32)
        begin
            val = {32'd0, gpr_file[code - REG_FIRST32][31:0]};
            return 1'b1;
        end
        if (code == REG_EIP)
        begin
            val = {32'd0, gpr_file[ENT_IP][31:0]};
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [63:0] count_value(input logic [1:0] w);
        logic [63:0] rcx;
        rcx = gpr_file[REG_RCX];
        if (w == AW_16)
            return {48'd0, rcx[15:0]};
        if (w == AW_32 || !host64)
            return {32'd0, rcx[31:0]};
        return rcx;
    endfunction

    function automatic logic condition_holds(input logic [3:0] cc, input logic [63:0] fl);
        logic r;
        case (cc[3:1])
            CC_O:    r = fl[FLAG_OF];
            CC_B:    r = fl[FLAG_CF];
            CC_Z:    r = fl[FLAG_ZF];
            CC_BE:   r = fl[FLAG_CF] | fl[FLAG_ZF];
            CC_S:    r = fl[FLAG_SF];
            CC_P:    r = fl[FLAG_PF];
            CC_L:    r = fl[FLAG_SF] ^ fl[FLAG_OF];
            default: r = fl[FLAG_ZF] | (fl[FLAG_SF] ^ fl[FLAG_OF]);
        endcase
        return r ^ cc[0];
    endfunction

    function automatic void pointer_view(input logic [63:0] a, input logic compat,
                                         output logic [63:0] ptr, output logic [3:0] psz);
        if (host64 && !compat)
        begin
            ptr = a;
            psz = PSZ_8;
        end
        else
        begin
            ptr = {32'd0, a[31:0]};
            psz = PSZ_4;
        end
    endfunction

    function automatic rsp_item_t resolve_next_pc(input req_item_t it);
        rsp_item_t   res;
        logic [63:0] off64;
        logic [63:0] len64;
        logic [63:0] fl;
        logic [63:0] imm;
        logic [63:0] ptr;
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] c;
        logic [3:0]  psz;
        logic        is_branch;
        logic        taken;
        off64     = {{32{it.signed_offset[31]}}, it.signed_offset};
        len64     = {60'd0, it.instr_length};
        fl        = gpr_file[ENT_FLAGS];
        imm       = '0;
        ptr       = '0;
        psz       = '0;
        is_branch = 1'b1;
        taken     = 1'b0;
        if (it.instr_class == CLS_NEAR_RET)
        begin
            pointer_view(gpr_file[REG_RSP], it.compat32, ptr, psz);
        end
        else if (it.instr_class == CLS_FAR_RET)
        begin
            imm = '0;
        end
        else if (it.instr_class == CLS_CALL_JMP)
        begin
            if (it.operand_kind == KIND_IMM)
            begin
                imm = ip_advance(len64 + off64);
            end
            else if (it.operand_kind == KIND_REG)
            begin
                if (operand_value(it.base_reg, r))
                    imm = r;
            end
            else if (it.operand_kind == KIND_MEM)
            begin
                v = '0;
                if (operand_value(it.base_reg, r))
                begin
                    v = v + r;
                    if (it.base_reg == REG_RIP || it.base_reg == REG_EIP)
                        v = v + len64;
                end
                if (operand_value(it.index_reg, r))
                    v = v + r * {60'd0, it.scale};
                v = v + off64;
                if (v != 0)
                    pointer_view(v, it.compat32, ptr, psz);
            end
        end
        else if (it.instr_class >= CLS_JCC_FIRST && it.instr_class <= CLS_JCC_LAST)
        begin
            taken = condition_holds(4'(it.instr_class - CLS_JCC_FIRST), fl);
        end
        else if (it.instr_class >= CLS_JCXZ && it.instr_class <= CLS_JRCXZ)
        begin
            if (it.instr_class == CLS_JCXZ)
                taken = count_value(AW_16) == 0;
            else if (it.instr_class == CLS_JECXZ)
                taken = count_value(AW_32) == 0;
            else
                taken = count_value(AW_64) == 0;
        end
        else if (it.instr_class >= CLS_LOOP && it.instr_class <= CLS_LOOPNE)
        begin
            c = 64'd1;
            if (it.count_width == AW_16 || it.count_width == AW_32
                || it.count_width == AW_64)
                c = count_value(it.count_width);
            taken = c != 1;
            if (it.instr_class == CLS_LOOPE)
                taken = taken & fl[FLAG_ZF];
            if (it.instr_class == CLS_LOOPNE)
                taken = taken & ~fl[FLAG_ZF];
        end
        else
        begin
            is_branch = 1'b0;
        end
        if (taken && it.operand_kind == KIND_IMM)
            imm = ip_advance(len64 + off64);
        if (imm == 0 && ptr == 0 && psz == 0)
        begin
            imm = ip_advance(len64);
            res.branch_status = is_branch ? ST_NOT_TAKEN : ST_NONE;
        end
        else
        begin
            res.branch_status = is_branch ? ST_TAKEN : ST_NONE;
        end
        res.target_address  = imm;
        res.pointer_address = ptr;
        res.pointer_size    = psz;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 18; i++)
                gpr_file[i] = '0;
            host64 = 1'b1;
            next_pc_expected.delete();
            pending_count = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                seen_rsp = rsp_item;
                if (next_pc_expected.size() == 0)
                begin
                    report_mismatch("response with nothing expected", '0,
                                    seen_rsp.target_address);
                end
                else
                begin
                    want_rsp = next_pc_expected.pop_front();
                    if (seen_rsp.branch_status !== want_rsp.branch_status)
                        report_mismatch("branch_status", 64'(want_rsp.branch_status),
                                        64'(seen_rsp.branch_status));
                    if (seen_rsp.target_address !== want_rsp.target_address)
                        report_mismatch("target_address", want_rsp.target_address,
                                        seen_rsp.target_address);
                    if (seen_rsp.pointer_address !== want_rsp.pointer_address)
                        report_mismatch("pointer_address", want_rsp.pointer_address,
                                        seen_rsp.pointer_address);
                    if (seen_rsp.pointer_size !== want_rsp.pointer_size)
                        report_mismatch("pointer_size", 64'(want_rsp.pointer_size),
                                        64'(seen_rsp.pointer_size));
                end
            end
            if (cfg_valid && cfg_ready)
                host64 = cfg_data;
            if (req_valid && !req_stall)
            begin
                if (req_item.req_type == REQ_RESOLVE)
                    next_pc_expected.push_back(resolve_next_pc(req_item));
                else if (req_item.write_reg <= ENT_FLAGS)
                    gpr_file[req_item.write_reg] = req_item.write_value;
            end
            pending_count = next_pc_expected.size();
        end
    end

endmodule

FILE: bench/x86_next_pc_resolver_tb.sv
// x86_next_pc_resolver_tb: stimulus, clock, reset and verdict for the next-pc resolver
// drives directed then random request transfers across host modes with random idling
// depends on xnpr_pkg, x86_next_pc_resolver and x86_next_pc_resolver_checker
`timescale 1ns / 100ps

module x86_next_pc_resolver_tb;

    import xnpr_pkg::*;

    localparam logic [4:0] CLS_NONE    = 5'd0;
    localparam logic [4:0] CLS_UNKNOWN = 5'd31;
    localparam logic [4:0] REG_NONE    = 5'd26;
    localparam logic [4:0] ENT_BEYOND  = 5'd31;
    localparam logic [1:0] KIND_OTHER  = 2'd3;
    localparam logic [1:0] AW_INVALID  = 2'd3;
    localparam int         IDLE_LIMIT  = 2000;
    localparam int         PHASE_ITEMS = 212;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_item_t req_item;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_item_t rsp_item;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_data;
    int        mismatch_count;
    int        pending_count;
    int        idle_cycles = 0;
    logic      sender_burst;

    x86_next_pc_resolver DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    x86_next_pc_resolver_checker next_pc_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_item       (req_item),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp_item       (rsp_item),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic req_item_t reg_write(input logic [4:0] entry, input logic [63:0] value);
        req_item_t it;
        it             = '0;
        it.req_type    = REQ_WRITE;
        it.write_reg   = entry;
        it.write_value = value;
        return it;
    endfunction

    function automatic req_item_t resolve_item(input logic [4:0] cls, input logic [3:0] len,
                                               input logic [1:0] kind, input logic [4:0] base,
                                               input logic [4:0] idx, input logic [3:0] scale,
                                               input logic [31:0] off, input logic [1:0] aw,
                                               input logic compat);
        req_item_t it;
        it               = '0;
        it.req_type      = REQ_RESOLVE;
        it.instr_class   = cls;
        it.instr_length  = len;
        it.operand_kind  = kind;
        it.base_reg      = base;
        it.index_reg     = idx;
        it.scale         = scale;
        it.signed_offset = off;
        it.count_width   = aw;
        it.compat32      = compat;
        return it;
    endfunction

    function automatic logic [63:0] interesting_value();
        case ($urandom_range(0, 7))
            0:       return 64'd0;
            1:       return 64'd1;
            2:       return 64'($urandom_range(0, 255));
            3:       return {32'd0, $urandom};
            4:       return {$urandom, 32'd0};
            5:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic req_item_t random_request();
        req_item_t it;
        it.req_type      = REQ_RESOLVE;
        it.write_reg     = 5'($urandom);
        it.write_value   = {$urandom, $urandom};
        it.instr_class   = 5'($urandom);
        it.instr_length  = 4'($urandom);
        it.operand_kind  = 2'($urandom);
        it.base_reg      = 5'($urandom);
        it.index_reg     = 5'($urandom);
        it.scale         = 4'($urandom);
        it.signed_offset = $urandom;
        it.count_width   = 2'($urandom);
        it.compat32      = 1'($urandom);
        if ($urandom_range(0, 3) == 0)
        begin
            it.req_type = REQ_WRITE;
            case ($urandom_range(0, 7))
                0:       it.write_reg = REG_RCX;
                1:       it.write_reg = ENT_IP;
                2:       it.write_reg = ENT_FLAGS;
                3:       it.write_reg = REG_RSP;
                4:       it.write_reg = 5'($urandom);
                default: it.write_reg = 5'($urandom_range(0, 17));
            endcase
            it.write_value = interesting_value();
            return it;
        end
        if ($urandom_range(0, 2) == 0)
            it.instr_class = CLS_CALL_JMP;
        if (it.instr_class != CLS_CALL_JMP && $urandom_range(0, 3) != 0)
            it.operand_kind = KIND_IMM;
        if ($urandom_range(0, 7) != 0)
            it.base_reg = 5'($urandom_range(0, 26));
        if ($urandom_range(0, 7) != 0)
            it.index_reg = 5'($urandom_range(0, 26));
        if ($urandom_range(0, 3) != 0)
            it.scale = 4'(1 << $urandom_range(0, 3));
        case ($urandom_range(0, 7))
            0:       it.signed_offset = '0;
            1:       it.signed_offset = 32'($urandom_range(0, 64)) - 32'd32;
            2:       it.signed_offset = -32'(it.instr_length);
            3:       it.signed_offset = 32'h7FFF_FFFF;
            4:       it.signed_offset = 32'h8000_0000;
            default: ;
        endcase
        return it;
    endfunction

    task automatic send_req(input req_item_t it);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= it;
        do @(posedge clk); while (req_stall);
    endtask

    // every expected response in, then idle clocks for trailing register writes
    task automatic settle();
        req_valid <= 1'b0;
        do @(negedge clk); while (pending_count != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_host_mode(input logic is_64bit);
        cfg_valid <= 1'b1;
        cfg_data  <= is_64bit;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // response side: random hold-off after transfers outside quiet stretches, one long hold to back up the pipe
    initial
    begin
        int  hold;
        int  taken_count;
        logic quiet;
        rsp_stall   = 1'b0;
        hold        = 0;
        taken_count = 0;
        quiet       = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                taken_count++;
                if (taken_count % 64 == 0)
                    quiet = ($urandom_range(0, 2) == 0);
                if (taken_count == 300)
                    hold = 80;
                else if (!quiet)
                    hold = $urandom_range(0, 5);
            end
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                hold--;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[x86_next_pc_resolver] ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req_item     = '0;
        cfg_valid    = 1'b0;
        cfg_data     = 1'b0;
        sender_burst = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        settle();
        set_host_mode(1'b1);
        send_req(reg_write(ENT_IP, 64'h0000_7FFF_0000_1000));
        send_req(reg_write(ENT_FLAGS, 64'h0000_0000_0000_08C5));
        send_req(reg_write(REG_RSP, 64'h0000_0001_0000_0000));
        send_req(reg_write(REG_RCX, 64'h0000_0001_0000_0000));
        send_req(reg_write(ENT_BEYOND, '1));
        send_req(resolve_item(CLS_NONE, 4'd15, KIND_IMM, REG_NONE, REG_NONE, 4'd1, '0,
                              AW_16, 1'b0));
        send_req(resolve_item(CLS_NEAR_RET, 4'd1, KIND_OTHER, REG_NONE, REG_NONE, 4'd1, '0,
                              AW_64, 1'b0));
        // stack pointer truncates to zero under a 32-bit program
        send_req(resolve_item(CLS_NEAR_RET, 4'd1, KIND_OTHER, REG_NONE, REG_NONE, 4'd1, '0,
                              AW_64, 1'b1));
        send_req(resolve_item(CLS_FAR_RET, 4'd1, KIND_OTHER, REG_NONE, REG_NONE, 4'd1, '0,
                              AW_64, 1'b0));
        send_req(resolve_item(CLS_CALL_JMP, 4'd5, KIND_IMM, REG_NONE, REG_NONE, 4'd1,
                              32'h7FFF_FFFF, AW_64, 1'b0));
        send_req(resolve_item(CLS_CALL_JMP, 4'd5, KIND_IMM, REG_NONE, REG_NONE, 4'd1,
                              32'h8000_0000, AW_64, 1'b0));
        send_req(resolve_item(CLS_CALL_JMP, 4'd2, KIND_REG, REG_RCX, REG_NONE, 4'd1, '0,
                              AW_64, 1'b0));
        send_req(resolve_item(CLS_CALL_JMP, 4'd6, KIND_MEM, REG_RIP, REG_RCX, 4'd8,
                              32'hFFFF_FFFF, AW_64, 1'b0));
        send_req(resolve_item(CLS_CALL_JMP, 4'd6, KIND_MEM, REG_NONE, REG_NONE, 4'd8, '0,
                              AW_64, 1'b0));
        send_req(resolve_item(CLS_CALL_JMP, 4'd7, KIND_MEM, REG_LAST32, REG_FIRST32, 4'd4,
                              32'h0000_0100, AW_64, 1'b1));
        send_req(resolve_item(CLS_JCC_FIRST, 4'd2, KIND_IMM, REG_NONE, REG_NONE, 4'd1,
                              32'hFFFF_FF80, AW_64, 1'b0));
        send_req(resolve_item(CLS_JCC_LAST, 4'd2, KIND_IMM, REG_NONE, REG_NONE, 4'd1,
                              32'h0000_0040, AW_64, 1'b0));
        // condition holds but the operand is not an immediate
        send_req(resolve_item(CLS_JCC_FIRST, 4'd3, KIND_REG, REG_RCX, REG_NONE, 4'd1,
                              32'h0000_0040, AW_64, 1'b0));
        send_req(resolve_item(CLS_JCXZ, 4'd2, KIND_IMM, REG_NONE, REG_NONE, 4'd1,
                              32'h0000_0010, AW_64, 1'b0));
        send_req(resolve_item(CLS_JRCXZ, 4'd2, KIND_IMM, REG_NONE, REG_NONE, 4'd1,
                              32'h0000_0010, AW_64, 1'b0));
        send_req(resolve_item(CLS_LOOP, 4'd2, KIND_IMM, REG_NONE, REG_NONE, 4'd1,
                              32'hFFFF_FFF0, AW_16, 1'b0));
        send_req(resolve_item(CLS_LOOPNE, 4'd2, KIND_IMM, REG_NONE, REG_NONE, 4'd1,
                              32'hFFFF_FFF0, AW_64, 1'b0));
        send_req(resolve_item(CLS_LOOPE, 4'd2, KIND_IMM, REG_NONE, REG_NONE, 4'd1,
                              32'hFFFF_FFF0, AW_INVALID, 1'b0));
        // target of exactly zero falls through
        send_req(reg_write(ENT_IP, 64'h0000_0000_0000_0010));
        send_req(resolve_item(CLS_CALL_JMP, 4'd0, KIND_IMM, REG_NONE, REG_NONE, 4'd1,
                              32'hFFFF_FFF0, AW_64, 1'b0));

        settle();
        set_host_mode(1'b0);
        send_req(resolve_item(CLS_JRCXZ, 4'd2, KIND_IMM, REG_NONE, REG_NONE, 4'd1,
                              32'h0000_0010, AW_64, 1'b0));
        send_req(resolve_item(CLS_CALL_JMP, 4'd2, KIND_REG, REG_RCX, REG_NONE, 4'd1, '0,
                              AW_64, 1'b0));
        send_req(resolve_item(CLS_CALL_JMP, 4'd6, KIND_MEM, REG_RIP, REG_EIP, 4'd1, '0,
                              AW_64, 1'b0));
        send_req(resolve_item(CLS_UNKNOWN, 4'd3, KIND_IMM, REG_NONE, REG_NONE, 4'd1, '0,
                              AW_64, 1'b0));

        for (int ph = 0; ph < 4; ph++)
        begin
            settle();
            set_host_mode((ph % 2 == 0) ? 1'b1 : 1'b0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 40 == 0)
                    sender_burst = ($urandom_range(0, 2) == 0);
                send_req(random_request());
            end
        end

        settle();
        repeat (6) @(posedge clk);
        if (mismatch_count == 0)
            $display("[x86_next_pc_resolver] OK");
        else
            $display("[x86_next_pc_resolver] ERROR");
        $finish;
    end

endmodule
